>>> rtl/fhd_pkg.sv
// ----------------------------------------------------------------------------
// fhd_pkg: shared types and constants of the frame header deframer
// Holds the phase encoding, result codes, register indexes and the word
// structures that pass between the step logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package fhd_pkg;

    // Header geometry and default trailer length.
    localparam int FHD_HDR_BYTES = 20;
    localparam int FHD_MAC_BYTES = 16;
    localparam int FHD_IDX_W     = 5;
    localparam int FHD_BODY_W    = 33;

    // Sync word, first byte in entry 0 ('N', 'D', 'P', '1').
    localparam logic [3:0][7:0] FHD_SYNC = {8'h31, 8'h50, 8'h44, 8'h4E};

    // Configuration register indexes.
    localparam logic [1:0] CFG_PAYLOAD_LIMIT = 2'd0;
    localparam logic [1:0] CFG_KNOWN_FLAGS   = 2'd1;
    localparam logic [1:0] CFG_MAC_FLAG      = 2'd2;

    // Configuration reset values.
    localparam logic [31:0] CFG_PAYLOAD_LIMIT_RST = 32'd65536;
    localparam logic [15:0] CFG_KNOWN_FLAGS_RST   = 16'd1;
    localparam logic [15:0] CFG_MAC_FLAG_RST      = 16'd1;

    // Input word kinds.
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Section tags.
    localparam logic [1:0] SEC_HEADER  = 2'd0;
    localparam logic [1:0] SEC_PAYLOAD = 2'd1;
    localparam logic [1:0] SEC_MAC     = 2'd2;
    localparam logic [1:0] SEC_NONE    = 2'd3;

    // Event codes.
    localparam logic [2:0] EV_MORE     = 3'd0;
    localparam logic [2:0] EV_HDR_OK   = 3'd1;
    localparam logic [2:0] EV_COMPLETE = 3'd2;
    localparam logic [2:0] EV_ERROR    = 3'd3;
    localparam logic [2:0] EV_REFUSED  = 3'd4;

    // Error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_FRAME = 2'd1;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd2;

    // Deframer phase, one-hot.
    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_BODY   = 4'b0010,
        PH_FRAME  = 4'b0100,
        PH_ERROR  = 4'b1000
    } fhd_phase_t;

    // Header store as a packed byte array, entry 0 is the first byte.
    typedef logic [FHD_HDR_BYTES-1:0][7:0] fhd_hdr_t;

    // Control state carried from word to word.
    typedef struct packed {
        fhd_phase_t              phase;
        logic [FHD_IDX_W-1:0]    header_count;
        logic [FHD_BODY_W-1:0]   body_remaining;
        logic                    magic_ok;
        logic [1:0]              error_held;
    } fhd_state_t;

    // One result word.
    typedef struct packed {
        logic [7:0]  byte_out;
        logic [1:0]  section;
        logic [2:0]  event_res;
        logic [1:0]  error_code;
        logic [7:0]  hdr_version;
        logic [7:0]  hdr_kind;
        logic [15:0] hdr_flags;
        logic [31:0] hdr_request_id;
        logic [15:0] hdr_command;
        logic [15:0] hdr_status;
        logic [31:0] hdr_payload_len;
    } fhd_result_t;

    // Header store write request.
    typedef struct packed {
        logic                 en;
        logic [FHD_IDX_W-1:0] idx;
        logic [7:0]           data;
    } fhd_store_wr_t;

endpackage

`default_nettype wire

>>> rtl/fhd_step.sv
// ----------------------------------------------------------------------------
// fhd_step: per-word decision logic of the frame header deframer
// From the current state, header store, configuration and one input word it
// forms the next state, the header store write and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module fhd_step
    import fhd_pkg::*;
#(
    parameter int MAC_BYTES = FHD_MAC_BYTES
) (
    input  wire fhd_state_t    cur,
    input  wire fhd_hdr_t      store,
    input  wire logic [31:0]   payload_limit,
    input  wire logic [15:0]   known_flags_mask,
    input  wire logic [15:0]   mac_flag_mask,
    input  wire logic          in_kind,
    input  wire logic [7:0]    in_byte,
    output fhd_state_t         nxt,
    output fhd_store_wr_t      store_wr,
    output fhd_result_t        res
);

    localparam logic [FHD_IDX_W-1:0] LAST_IDX = FHD_IDX_W'(FHD_HDR_BYTES - 1);
    localparam logic [FHD_BODY_W-1:0] MAC_LEN = FHD_BODY_W'(MAC_BYTES);

    logic [FHD_IDX_W-1:0]  idx;
    logic                  hdr_write;
    fhd_hdr_t              view;
    logic [15:0]           flags;
    logic [31:0]           plen;
    logic [FHD_BODY_W-1:0] mac_len;
    logic                  magic_next;
    logic                  bad_frame;
    logic [FHD_BODY_W-1:0] body_total;
    logic [FHD_BODY_W-1:0] body_dec;

    // Write slot, clamped to the last header entry.
    assign idx = (cur.header_count >= LAST_IDX) ? LAST_IDX : cur.header_count;
    assign hdr_write = (in_kind == KIND_BYTE) && (cur.phase == PH_HEADER);

    // Header as it stands after this word, so the last byte is seen at once.
    always_comb begin
        view = store;
        if (hdr_write) begin
            view[idx] = in_byte;
        end
    end

    assign flags   = {view[7], view[6]};
    assign plen    = {view[19], view[18], view[17], view[16]};
    assign mac_len = ((flags & mac_flag_mask) != 16'd0) ? MAC_LEN : '0;

    // Sync word check on the first four bytes.
    assign magic_next = cur.magic_ok &
                        !((idx < FHD_IDX_W'(4)) && (in_byte != FHD_SYNC[idx[1:0]]));
    assign bad_frame  = !magic_next || ((flags & ~known_flags_mask) != 16'd0);
    assign body_total = {1'b0, plen} + mac_len;
    assign body_dec   = cur.body_remaining - FHD_BODY_W'(1);

    assign store_wr.en   = hdr_write;
    assign store_wr.idx  = idx;
    assign store_wr.data = in_byte;

    // Next state and result word.
    always_comb begin
        nxt           = cur;
        res           = '0;
        res.section   = SEC_NONE;
        res.event_res = EV_MORE;

        if (in_kind == KIND_RELEASE) begin
            nxt.phase          = PH_HEADER;
            nxt.header_count   = '0;
            nxt.body_remaining = '0;
            nxt.magic_ok       = 1'b1;
            nxt.error_held     = ERR_NONE;
        end else begin
            case (cur.phase)
                PH_FRAME: begin
                    res.event_res = EV_REFUSED;
                end
                PH_ERROR: begin
                    res.event_res  = EV_REFUSED;
                    res.error_code = cur.error_held;
                end
                PH_HEADER: begin
                    res.byte_out     = in_byte;
                    res.section      = SEC_HEADER;
                    nxt.magic_ok     = magic_next;
                    nxt.header_count = idx + FHD_IDX_W'(1);
                    if (idx == LAST_IDX) begin
                        if (bad_frame || (plen > payload_limit)) begin
                            nxt.phase      = PH_ERROR;
                            nxt.error_held = bad_frame ? ERR_BAD_FRAME : ERR_TOO_LARGE;
                            res.event_res  = EV_ERROR;
                            res.error_code = bad_frame ? ERR_BAD_FRAME : ERR_TOO_LARGE;
                        end else begin
                            nxt.body_remaining = body_total;
                            if (body_total == '0) begin
                                nxt.phase     = PH_FRAME;
                                res.event_res = EV_COMPLETE;
                            end else begin
                                nxt.phase     = PH_BODY;
                                res.event_res = EV_HDR_OK;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    if (cur.body_remaining == '0) begin
                        // Cannot happen in normal flow; close the frame.
                        nxt.phase     = PH_FRAME;
                        res.event_res = EV_REFUSED;
                    end else begin
                        res.byte_out = in_byte;
                        res.section  = (cur.body_remaining > mac_len) ? SEC_PAYLOAD : SEC_MAC;
                        nxt.body_remaining = body_dec;
                        if (body_dec == '0) begin
                            nxt.phase     = PH_FRAME;
                            res.event_res = EV_COMPLETE;
                        end
                    end
                end
                default: begin
                    nxt = cur;
                end
            endcase
        end

        // Decoded header rides only on header-accepted and complete words.
        if ((res.event_res == EV_HDR_OK) || (res.event_res == EV_COMPLETE)) begin
            res.hdr_version     = view[4];
            res.hdr_kind        = view[5];
            res.hdr_flags       = flags;
            res.hdr_request_id  = {view[11], view[10], view[9], view[8]};
            res.hdr_command     = {view[13], view[12]};
            res.hdr_status      = {view[15], view[14]};
            res.hdr_payload_len = plen;
        end
    end

endmodule

`default_nettype wire

>>> rtl/frame_header_deframer.sv
// ----------------------------------------------------------------------------
// frame_header_deframer: byte stream frame header check and section tagging
// Latency: the result word of an accepted input word is registered and appears in the cycle after.
// Throughput: one word per cycle while m_ready takes each result, set by the single registered step.
// Reset: synchronous active-low aresetn; header phase, default registers.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_header_deframer
    import fhd_pkg::*;
#(
    parameter int MAC_BYTES = FHD_MAC_BYTES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wr_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [7:0]  s_byte_value,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_byte_out,
    output logic [1:0]       m_section,
    output logic [2:0]       m_event_res,
    output logic [1:0]       m_error_code,
    output logic [7:0]       m_hdr_version,
    output logic [7:0]       m_hdr_kind,
    output logic [15:0]      m_hdr_flags,
    output logic [31:0]      m_hdr_request_id,
    output logic [15:0]      m_hdr_command,
    output logic [15:0]      m_hdr_status,
    output logic [31:0]      m_hdr_payload_len
);

    logic [31:0]   payload_limit_reg;
    logic [15:0]   known_flags_reg;
    logic [15:0]   mac_flag_reg;
    fhd_state_t    state_reg;
    fhd_state_t    state_next;
    fhd_hdr_t      store_reg;
    fhd_store_wr_t store_wr;
    fhd_result_t   result_reg;
    fhd_result_t   result_next;
    logic          m_valid_reg;
    logic          accept;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_limit_reg <= CFG_PAYLOAD_LIMIT_RST;
            known_flags_reg   <= CFG_KNOWN_FLAGS_RST;
            mac_flag_reg      <= CFG_MAC_FLAG_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PAYLOAD_LIMIT: payload_limit_reg <= cfg_wr_data;
                CFG_KNOWN_FLAGS:   known_flags_reg   <= cfg_wr_data[15:0];
                CFG_MAC_FLAG:      mac_flag_reg      <= cfg_wr_data[15:0];
                default:           payload_limit_reg <= payload_limit_reg;
            endcase
        end
    end

    // The output register frees up whenever its word is taken.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    fhd_step #(
        .MAC_BYTES (MAC_BYTES)
    ) u_step (
        .cur              (state_reg),
        .store            (store_reg),
        .payload_limit    (payload_limit_reg),
        .known_flags_mask (known_flags_reg),
        .mac_flag_mask    (mac_flag_reg),
        .in_kind          (s_kind),
        .in_byte          (s_byte_value),
        .nxt              (state_next),
        .store_wr         (store_wr),
        .res              (result_next)
    );

    // Control state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase          <= PH_HEADER;
            state_reg.header_count   <= '0;
            state_reg.body_remaining <= '0;
            state_reg.magic_ok       <= 1'b1;
            state_reg.error_held     <= ERR_NONE;
            m_valid_reg              <= 1'b0;
        end else if (accept) begin
            state_reg   <= state_next;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Header store and result payload need no reset.
    always_ff @(posedge aclk) begin
        if (accept && store_wr.en) begin
            store_reg[store_wr.idx] <= store_wr.data;
        end
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_byte_out        = result_reg.byte_out;
    assign m_section         = result_reg.section;
    assign m_event_res       = result_reg.event_res;
    assign m_error_code      = result_reg.error_code;
    assign m_hdr_version     = result_reg.hdr_version;
    assign m_hdr_kind        = result_reg.hdr_kind;
    assign m_hdr_flags       = result_reg.hdr_flags;
    assign m_hdr_request_id  = result_reg.hdr_request_id;
    assign m_hdr_command     = result_reg.hdr_command;
    assign m_hdr_status      = result_reg.hdr_status;
    assign m_hdr_payload_len = result_reg.hdr_payload_len;

    // An error hold always carries a nonzero error code.
    a_error_held_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_ERROR) |-> (state_reg.error_held != ERR_NONE))
        else $error("error phase without a held error code");

    // The body phase always has bytes left to consume.
    a_body_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_BODY) |-> (state_reg.body_remaining != '0))
        else $error("body phase with nothing remaining");

    // A release word returns the deframer to a fresh header phase.
    a_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_kind == KIND_RELEASE)) |=>
            ((state_reg.phase == PH_HEADER) && (state_reg.header_count == '0) &&
             (m_section == SEC_NONE) && (m_event_res == EV_MORE)))
        else $error("release did not restart the header phase");

    // A refused word never claims to have consumed a byte.
    a_refused_unconsumed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_res == EV_REFUSED)) |->
            ((m_section == SEC_NONE) && (m_byte_out == 8'd0)))
        else $error("refused word tagged as consumed");

endmodule

`default_nettype wire
